// ===== sv/bbc_pkg.sv =====
package bbc_pkg;

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_PIN     = 2'd2,
      CMD_UNPIN   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_PREP = 2'd1,
      FSM_SCAN = 2'd2,
      FSM_DONE = 2'd3
   } fsm_type;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  slot_index;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [4:0] slot;
      logic       hit;
      logic       needs_fill;
      logic [1:0] status;
   } rsp_type;

   // Per-slot contents that circulate through the ring.
   // bucket caches block mod bucket count for the slot's tag.
   typedef struct packed {
      logic [7:0]  device;
      logic [31:0] block;
      logic [7:0]  count;
      logic [31:0] rtime;
      logic        filled;
      logic [7:0]  bucket;
   } entry_type;

endpackage

// ===== sv/bbc_cell.sv =====
// One ring position: holds a slot and its number, passes it on when shifting.
module bbc_cell #(
   parameter int IDX_W = 5
) (
   input  logic                     clock,
   input  logic                     load,
   input  logic                     shift,
   input  bbc_pkg::entry_type       load_entry,
   input  logic [IDX_W-1:0]         load_id,
   input  bbc_pkg::entry_type       prev_entry,
   input  logic [IDX_W-1:0]         prev_id,
   output bbc_pkg::entry_type       entry,
   output logic [IDX_W-1:0]         id
);
   import bbc_pkg::*;

   entry_type        entry_ff;
   logic [IDX_W-1:0] id_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= load_entry;
         id_ff    <= load_id;
      end else if (shift) begin
         entry_ff <= prev_entry;
         id_ff    <= prev_id;
      end
   end

   assign entry = entry_ff;
   assign id    = id_ff;
endmodule

// ===== sv/block_buffer_cache_lru.sv =====
// Tag store of a disk block buffer cache with oldest-released replacement.
// The slots sit in a ring of cells that rotates one position per clock in the
// search and update turns; the head cell is inspected, and on the second turn
// updated, as each slot passes it. A command word is taken when start is high
// and busy is low; busy then stays high until the result has been shown. Every
// command runs the same schedule: reduce the block number to its bucket (byte
// fold, reciprocal multiply, subtract), a search turn over all slots (tag hit,
// oldest free slot in the bucket, oldest free slot overall), an update turn
// that applies the update as the chosen slot passes the head, then the result.
// rsp_word is valid for exactly one cycle with rsp_valid high; the receiver
// cannot stall it and must take the word in that cycle. Reset loads every slot
// at once (device 0, block = slot number, count 0, time 0, not filled).
module block_buffer_cache_lru #(
   parameter int NUM_SLOTS   = 32,
   parameter int NUM_BUCKETS = 31
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bbc_pkg::req_type req_word,
   output logic             rsp_valid,
   output bbc_pkg::rsp_type rsp_word
);
   import bbc_pkg::*;

   localparam int IDX_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W       = $clog2(NUM_SLOTS + 1);
   localparam int PREP_CYCLES = 3;
   // 256^k mod buckets, for folding the block number byte by byte
   localparam logic [7:0]  FOLD_C1 = 8'(256 % NUM_BUCKETS);
   localparam logic [7:0]  FOLD_C2 = 8'(65536 % NUM_BUCKETS);
   localparam logic [7:0]  FOLD_C3 = 8'(16777216 % NUM_BUCKETS);
   // ceil(2^26 / buckets): exact quotient for any folded value below 2^18
   localparam logic [26:0] REC_M   =
      27'((64'd67108864 + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

   // ring
   entry_type        ent  [NUM_SLOTS];
   logic [IDX_W-1:0] ids  [NUM_SLOTS];
   entry_type        head_new;
   logic             shift;

   // control
   fsm_type          state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             phase_ff;
   logic             accept;
   logic             last_slot;
   req_type          req_ff;
   rsp_type          rsp_ff, rsp_in;

   // bucket of the request block
   logic [17:0]      fold_in, fold_ff, quot_ff, rem_full;
   logic [44:0]      recip_prod;
   logic [7:0]       rbkt_ff;

   // scan results
   logic             hit_ff;
   logic [IDX_W-1:0] hit_id_ff;
   logic             bf_ff, af_ff;
   logic [IDX_W-1:0] bid_ff, aid_ff;
   logic [31:0]      bt_ff, at_ff;

   entry_type        h;
   logic [IDX_W-1:0] hid;
   assign h   = ent[0];
   assign hid = ids[0];

   genvar g;
   generate
      for (g = 0; g < NUM_SLOTS; g++) begin : g_ring
         entry_type le;
         always_comb begin
            le        = '0;
            le.block  = 32'(g);
            le.bucket = 8'(g % NUM_BUCKETS);
         end
         bbc_cell #(.IDX_W(IDX_W)) u_cell (
            .clock      (clock),
            .load       (reset),
            .shift      (shift),
            .load_entry (le),
            .load_id    (IDX_W'(g)),
            .prev_entry ((g == NUM_SLOTS - 1) ? head_new : ent[(g + 1) % NUM_SLOTS]),
            .prev_id    (ids[(g + 1) % NUM_SLOTS]),
            .entry      (ent[g]),
            .id         (ids[g])
         );
      end
   endgenerate

   assign accept    = start && !busy;
   assign last_slot = (cnt_ff == CNT_W'(NUM_SLOTS - 1));

   // Turn 0 (phase 0): search. Turn 1 (phase 1): update the chosen slot.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (accept) state_in = FSM_PREP;
         FSM_PREP: if (cnt_ff == CNT_W'(PREP_CYCLES - 1)) state_in = FSM_SCAN;
         FSM_SCAN: if (phase_ff && last_slot) state_in = FSM_DONE;
         FSM_DONE: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      busy      = (state_ff != FSM_IDLE);
      rsp_valid = (state_ff == FSM_DONE);
      shift     = (state_ff == FSM_SCAN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         cnt_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            cnt_ff   <= '0;
            phase_ff <= 1'b0;
         end else if (state_ff == FSM_PREP) begin
            if (cnt_ff == CNT_W'(PREP_CYCLES - 1))
               cnt_ff <= '0;
            else
               cnt_ff <= cnt_ff + CNT_W'(1);
         end else if (state_ff == FSM_SCAN) begin
            if (last_slot) begin
               cnt_ff   <= '0;
               phase_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff + CNT_W'(1);
            end
         end
      end
   end

   // Bucket pipeline: fold bytes, estimate quotient, subtract.
   // req_ff holds still during prep, so all three stages settle before the search turn.
   assign fold_in = 18'(req_ff.block_number[7:0])
                  + 18'(req_ff.block_number[15:8])  * 18'(FOLD_C1)
                  + 18'(req_ff.block_number[23:16]) * 18'(FOLD_C2)
                  + 18'(req_ff.block_number[31:24]) * 18'(FOLD_C3);
   assign recip_prod = 45'(fold_ff) * 45'(REC_M);
   assign rem_full   = fold_ff - quot_ff * 18'(NUM_BUCKETS);

   always_ff @(posedge clock) begin
      fold_ff <= fold_in;
      quot_ff <= recip_prod[43:26];
      rbkt_ff <= rem_full[7:0];
   end

   // Selected target after the search turn
   logic             is_acq;
   logic             victim_ok;
   logic [IDX_W-1:0] victim;
   logic             tgt_ok;
   logic [IDX_W-1:0] tgt;
   logic             do_upd;
   assign is_acq    = (req_ff.command == CMD_ACQUIRE);
   assign victim_ok = bf_ff || af_ff;
   assign victim    = bf_ff ? bid_ff : aid_ff;
   assign tgt_ok    = is_acq ? (hit_ff || victim_ok)
                             : ({{(32-5){1'b0}}, req_ff.slot_index} < 32'(NUM_SLOTS));
   assign tgt       = is_acq ? (hit_ff ? hit_id_ff : victim) : IDX_W'(req_ff.slot_index);
   assign do_upd    = phase_ff && tgt_ok && (hid == tgt);

   always_comb begin
      head_new = h;
      if (do_upd) begin
         if (is_acq) begin
            if (hit_ff) begin
               if (h.count != COUNT_MAX) head_new.count = h.count + 8'd1;
               head_new.filled = 1'b1;
            end else begin
               head_new.device = req_ff.device;
               head_new.block  = req_ff.block_number;
               head_new.count  = 8'd1;
               head_new.filled = 1'b1;
               head_new.bucket = rbkt_ff;
            end
         end else if (req_ff.command == CMD_PIN) begin
            if (h.count != COUNT_MAX) head_new.count = h.count + 8'd1;
         end else if (h.count != 8'd0) begin
            head_new.count = h.count - 8'd1;
            // release that drops the last reference stamps the time
            if (req_ff.command == CMD_RELEASE && h.count == 8'd1)
               head_new.rtime = req_ff.now;
         end
      end
   end

   // response assembled from head as the target passes
   always_comb begin
      rsp_in = rsp_ff;
      if (do_upd) begin
         if (is_acq) begin
            rsp_in.slot       = 5'(tgt);
            rsp_in.hit        = hit_ff;
            rsp_in.needs_fill = hit_ff ? !h.filled : 1'b1;
            rsp_in.status     = ST_OK;
         end else begin
            rsp_in.status = (req_ff.command != CMD_PIN && h.count == 8'd0)
                            ? ST_UNDERFLOW : ST_OK;
         end
      end
   end

   // request capture and search; slots pass the head in index order, so a
   // strict compare keeps the lowest index on equal times
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_word;
         hit_ff <= 1'b0;
         bf_ff  <= 1'b0;
         af_ff  <= 1'b0;
         rsp_ff <= '{slot: (req_word.command == CMD_ACQUIRE) ? 5'd0 : req_word.slot_index,
                     hit: 1'b0, needs_fill: 1'b0,
                     status: (req_word.command == CMD_ACQUIRE) ? ST_NO_FREE : ST_OK};
      end else if (shift) begin
         rsp_ff <= rsp_in;
         if (!phase_ff) begin
            if (!hit_ff && h.device == req_ff.device && h.block == req_ff.block_number) begin
               hit_ff    <= 1'b1;
               hit_id_ff <= hid;
            end
            if (h.count == 8'd0 && h.bucket == rbkt_ff && (!bf_ff || h.rtime < bt_ff)) begin
               bf_ff  <= 1'b1;
               bid_ff <= hid;
               bt_ff  <= h.rtime;
            end
            if (h.count == 8'd0 && (!af_ff || h.rtime < at_ff)) begin
               af_ff  <= 1'b1;
               aid_ff <= hid;
               at_ff  <= h.rtime;
            end
         end
      end
   end

   assign rsp_word = rsp_ff;
endmodule

// ===== sv/bbc_checker.sv =====
module bbc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input bbc_pkg::rsp_type rsp_word
);
   import bbc_pkg::*;

   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("rsp_valid held two cycles");
   a_busy_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("idle during result");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status != 2'd3) else $error("bad status");
   a_hitfill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.status == ST_NO_FREE) |-> !rsp_word.needs_fill)
      else $error("fill on no free slot");
endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (.*);
